// ===== hdl/hdc_pkg.sv =====
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants of the disk controller port block
// Field widths, port and command codes, status values and FSM states.
// ----------------------------------------------------------------------------
package hdc_pkg;

  // Beat field widths.
  localparam int REQ_W     = 3;
  localparam int PORT_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int DREQ_W    = 2;
  localparam int UNIT_W    = 3;
  localparam int OFFS_W    = 23;
  localparam int CFG_IDX_W = 2;

  // Internal state widths.
  localparam int TRACK_W = 9;
  localparam int HEAD_W  = 2;
  localparam int SECT_W  = 5;
  localparam int BANK_W  = 2;
  localparam int BIDX_W  = 9;
  localparam int P1_W    = 15;

  // Disk geometry.
  localparam int SECTORS_PER_TRACK = 24;
  localparam int TRACK_COUNT       = 406;
  localparam int DRIVE_COUNT       = 8;

  // Request types.
  localparam logic [REQ_W-1:0] RQ_HOST_RD   = 3'd0;
  localparam logic [REQ_W-1:0] RQ_HOST_WR   = 3'd1;
  localparam logic [REQ_W-1:0] RQ_DISK_IN   = 3'd2;
  localparam logic [REQ_W-1:0] RQ_DISK_PULL = 3'd3;
  localparam logic [REQ_W-1:0] RQ_DISK_ERR  = 3'd4;

  // Host ports.
  localparam logic [PORT_W-1:0] PORT_STATUS  = 3'd1;
  localparam logic [PORT_W-1:0] PORT_CMD     = 3'd3;
  localparam logic [PORT_W-1:0] PORT_DATA_RD = 3'd5;
  localparam logic [PORT_W-1:0] PORT_DATA_WR = 3'd7;

  // Command codes from the high nibble of a command write.
  localparam logic [3:0] CMD_TRACK_SEEK = 4'h0;
  localparam logic [3:0] CMD_WR_SEC     = 4'h2;
  localparam logic [3:0] CMD_RD_SEC     = 4'h3;
  localparam logic [3:0] CMD_RD_SEC_ALT = 4'ha;
  localparam logic [3:0] CMD_WR_BUF     = 4'h4;
  localparam logic [3:0] CMD_RD_BUF     = 4'h5;

  // Disk requests.
  localparam logic [DREQ_W-1:0] DREQ_NONE  = 2'd0;
  localparam logic [DREQ_W-1:0] DREQ_READ  = 2'd1;
  localparam logic [DREQ_W-1:0] DREQ_WRITE = 2'd2;

  // Status values.
  localparam logic [BYTE_W-1:0] ST_READY      = 8'h80;
  localparam logic [BYTE_W-1:0] ST_NOT_READY  = 8'h01;
  localparam logic [BYTE_W-1:0] ST_WRITE_LOCK = 8'h80;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WPROT    = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL1,
    S_MUL2,
    S_RESP
  } state_t;

  // Geometry handed to the offset unit.
  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               head0;
    logic [SECT_W-1:0]  sector;
  } geom_t;

endpackage

// ===== hdl/hdc_in_if.sv =====
// ----------------------------------------------------------------------------
// hdc_in_if: input item channel
// Valid/ready channel carrying one host access or disk transfer per beat.
// ----------------------------------------------------------------------------
interface hdc_in_if;
  import hdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PORT_W-1:0] port;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output req_type, output port, output data, input ready);
  modport sink   (input valid, input req_type, input port, input data, output ready);
endinterface

// ===== hdl/hdc_out_if.sv =====
// ----------------------------------------------------------------------------
// hdc_out_if: result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface hdc_out_if;
  import hdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic [DREQ_W-1:0] disk_request;
  logic [UNIT_W-1:0] disk_unit;
  logic [OFFS_W-1:0] disk_offset;

  modport source (output valid, output read_data, output disk_request,
                  output disk_unit, output disk_offset, input ready);
  modport sink   (input valid, input read_data, input disk_request,
                  input disk_unit, input disk_offset, output ready);
endinterface

// ===== hdl/hdc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hdc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface hdc_cfg_if;
  import hdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hdc_sector_ram.sv =====
// ----------------------------------------------------------------------------
// hdc_sector_ram: sector buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdc_sector_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [hdc_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [hdc_pkg::BYTE_W-1:0] rdata
);
  import hdc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/hdc_offset_unit.sv =====
// ----------------------------------------------------------------------------
// hdc_offset_unit: sector byte offset calculator
// Two registered constant multiplies: logical sector, then byte offset.
// ----------------------------------------------------------------------------
module hdc_offset_unit #(
  parameter int SECTOR_BYTES = 256
) (
  input  logic                      clk,
  input  hdc_pkg::geom_t            geom,
  output logic [hdc_pkg::OFFS_W-1:0] offset
);
  import hdc_pkg::*;

  localparam int P2_W = P1_W + $clog2(SECTOR_BYTES + 1);

  logic [P1_W-1:0]   p1_nxt;
  logic [P1_W-1:0]   p1_r;
  logic [P2_W-1:0]   p2_nxt;
  logic [OFFS_W-1:0] p2_r;

  // Sector number across both sides of the platter.
  assign p1_nxt = P1_W'({geom.track, geom.head0}) * P1_W'(SECTORS_PER_TRACK)
                + P1_W'(geom.sector);
  assign p2_nxt = P2_W'(p1_r) * P2_W'(SECTOR_BYTES);

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= OFFS_W'(p2_nxt);
  end

  assign offset = p2_r;
endmodule

// ===== hdl/hard_disk_controller_ports_core.sv =====
// ----------------------------------------------------------------------------
// hard_disk_controller_ports_core: disk controller behind eight byte ports
// Sector buffer memory with a read/write-back sequencer and a disk request
// generator.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat carries
//   --------+-----------+-------------------------------------------------
//   in_ch   | sink      | req_type, port, data (host access or disk byte)
//   out_ch  | source    | read_data, disk_request, disk_unit, disk_offset
//   cfg_ch  | sink      | index, data (attached and write-protect masks)
//
// An item passes through accept (buffer memory read issued), execute (read
// data used, write-back, state update) and response; a sector command that
// issues a disk request also passes through the two-stage offset multiplier.
// One item is in flight at a time; the result register lets the next input
// beat be accepted while an earlier result waits on out_ch.ready, and a full
// result register holds the sequencer in the response cycle. Synchronous
// active-low reset clears all but the payload registers and buffer memory.
// Configuration beats are always accepted.
//
module hard_disk_controller_ports_core #(
  parameter int SECTOR_BYTES = 256,
  parameter int BUFFER_COUNT = 4
) (
  input logic     clk,
  input logic     rst_n,
  hdc_in_if.sink  in_ch,
  hdc_out_if.source out_ch,
  hdc_cfg_if.sink cfg_ch
);
  import hdc_pkg::*;

  localparam int XW    = $clog2(SECTOR_BYTES);
  localparam int DEPTH = BUFFER_COUNT * SECTOR_BYTES;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer.
  state_t state_r, state_nxt;
  logic   in_accept;
  logic   load_out;

  // Accepted item.
  logic [REQ_W-1:0]  item_req_r;
  logic [PORT_W-1:0] item_port_r;
  logic [BYTE_W-1:0] item_data_r;

  // Configuration registers.
  logic [BYTE_W-1:0] attached_r;
  logic [BYTE_W-1:0] wprot_r;

  // Controller state.
  logic [TRACK_W-1:0] track_r, track_nxt;
  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic [SECT_W-1:0]  sector_r, sector_nxt;
  logic [UNIT_W-1:0]  drive_r, drive_nxt;
  logic [BANK_W-1:0]  bank_r, bank_nxt;
  logic [BIDX_W-1:0]  bidx_r, bidx_nxt;
  logic [BIDX_W-1:0]  blimit_r, blimit_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic [BYTE_W-1:0]  status_r, status_nxt;
  logic [XW-1:0]      xfer_r, xfer_nxt;

  // Pending result.
  logic [BYTE_W-1:0] res_rd_r, res_rd_nxt;
  logic [DREQ_W-1:0] res_dreq_r, res_dreq_nxt;
  logic [UNIT_W-1:0] res_unit_r, res_unit_nxt;

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_rd_r;
  logic [DREQ_W-1:0] out_dreq_r;
  logic [UNIT_W-1:0] out_unit_r;
  logic [OFFS_W-1:0] out_offs_r;

  // Buffer memory ports.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Decode helpers.
  logic              host_ok;
  logic [AW-1:0]     host_addr;
  logic [AW-1:0]     xfer_addr;
  logic [XW-1:0]     xfer_inc;
  logic [3:0]        cmd;
  logic [1:0]        cmd_unit;
  logic [BANK_W-1:0] cmd_bank;
  logic [TRACK_W:0]  seek_raw;
  logic [TRACK_W-1:0] seek_track;
  logic [HEAD_W-1:0] cmd_head;
  logic [UNIT_W-1:0] cmd_drive;
  geom_t             geom;
  logic [OFFS_W-1:0] offset;

  // --------------------------------------------------------------------------
  // Sequencer: next state and outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (res_dreq_nxt != DREQ_NONE) ? S_MUL1 : S_RESP;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    load_out    = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);
  end

  assign in_accept = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Address generation. Buffer numbers are reduced modulo the buffer count
  // when a command selects them, so the stored bank is always in range.
  // --------------------------------------------------------------------------
  assign host_ok   = (bidx_r < blimit_r) && (bidx_r < SECTOR_BYTES);
  assign host_addr = AW'(bank_r * SECTOR_BYTES) + AW'(XW'(bidx_r));
  assign xfer_addr = AW'(bank_r * SECTOR_BYTES) + AW'(xfer_r);
  assign xfer_inc  = (xfer_r == XW'(SECTOR_BYTES - 1)) ? '0 : xfer_r + 1'b1;
  assign mem_raddr = (in_ch.req_type == RQ_DISK_PULL) ? xfer_addr : host_addr;

  // --------------------------------------------------------------------------
  // Command field decode.
  // --------------------------------------------------------------------------
  always_comb begin
    cmd        = item_data_r[7:4];
    cmd_unit   = item_data_r[3:2];
    cmd_bank   = item_data_r[1:0];
    for (int k = 0; k < 3; k++) begin
      if (cmd_bank >= BUFFER_COUNT) begin
        cmd_bank = cmd_bank - BANK_W'(BUFFER_COUNT);
      end
    end
    seek_raw   = {1'b0, item_data_r[0], low_r};
    seek_track = (seek_raw >= (TRACK_W+1)'(TRACK_COUNT)) ?
                 TRACK_W'(TRACK_COUNT - 1) : seek_raw[TRACK_W-1:0];
    cmd_head   = low_r[6:5];
    cmd_drive  = {cmd_unit, cmd_head[1]};
  end

  // --------------------------------------------------------------------------
  // Execute: use the read data, write back to the buffer, update state.
  // --------------------------------------------------------------------------
  always_comb begin
    track_nxt    = track_r;
    head_nxt     = head_r;
    sector_nxt   = sector_r;
    drive_nxt    = drive_r;
    bank_nxt     = bank_r;
    bidx_nxt     = bidx_r;
    blimit_nxt   = blimit_r;
    low_nxt      = low_r;
    status_nxt   = status_r;
    xfer_nxt     = xfer_r;
    res_rd_nxt   = res_rd_r;
    res_dreq_nxt = res_dreq_r;
    res_unit_nxt = res_unit_r;
    mem_we       = 1'b0;
    mem_waddr    = host_addr;
    mem_wdata    = item_data_r;

    if (state_r == S_EXEC) begin
      res_rd_nxt   = '0;
      res_dreq_nxt = DREQ_NONE;
      res_unit_nxt = '0;
      case (item_req_r)
        RQ_HOST_RD: begin
          if (!item_port_r[0]) begin
            res_rd_nxt = ST_READY;
          end else if (item_port_r == PORT_STATUS) begin
            res_rd_nxt = status_r;
          end else if (item_port_r == PORT_DATA_RD && host_ok) begin
            res_rd_nxt = mem_rdata;
            bidx_nxt   = bidx_r + 1'b1;
          end
        end
        RQ_HOST_WR: begin
          if (item_port_r == PORT_DATA_WR) begin
            low_nxt = item_data_r;
            if (host_ok) begin
              mem_we   = 1'b1;
              bidx_nxt = bidx_r + 1'b1;
            end
          end else if (item_port_r == PORT_CMD) begin
            status_nxt = '0;
            unique case (cmd) inside
              CMD_TRACK_SEEK: begin
                track_nxt = seek_track;
              end
              CMD_WR_SEC, CMD_RD_SEC, CMD_RD_SEC_ALT: begin
                head_nxt   = cmd_head;
                drive_nxt  = cmd_drive;
                sector_nxt = low_r[4:0];
                bank_nxt   = cmd_bank;
                if (cmd_drive >= DRIVE_COUNT || !attached_r[cmd_drive]) begin
                  status_nxt = ST_NOT_READY;
                end else if (cmd == CMD_WR_SEC && wprot_r[cmd_drive]) begin
                  status_nxt = ST_WRITE_LOCK;
                end else begin
                  xfer_nxt     = '0;
                  res_dreq_nxt = (cmd == CMD_WR_SEC) ? DREQ_WRITE : DREQ_READ;
                  res_unit_nxt = cmd_drive;
                end
              end
              CMD_WR_BUF, CMD_RD_BUF: begin
                bank_nxt   = cmd_bank;
                blimit_nxt = (low_r == '0) ? BIDX_W'(256) : BIDX_W'(low_r);
                bidx_nxt   = '0;
              end
              default: begin
              end
            endcase
          end
        end
        RQ_DISK_IN: begin
          mem_we    = 1'b1;
          mem_waddr = xfer_addr;
          xfer_nxt  = xfer_inc;
        end
        RQ_DISK_PULL: begin
          res_rd_nxt = mem_rdata;
          xfer_nxt   = xfer_inc;
        end
        RQ_DISK_ERR: begin
          status_nxt = ST_NOT_READY;
          xfer_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      track_r    <= '0;
      head_r     <= '0;
      sector_r   <= '0;
      drive_r    <= '0;
      bank_r     <= '0;
      bidx_r     <= '0;
      blimit_r   <= BIDX_W'(256);
      low_r      <= '0;
      status_r   <= '0;
      xfer_r     <= '0;
      res_rd_r   <= '0;
      res_dreq_r <= DREQ_NONE;
      res_unit_r <= '0;
    end else begin
      state_r    <= state_nxt;
      track_r    <= track_nxt;
      head_r     <= head_nxt;
      sector_r   <= sector_nxt;
      drive_r    <= drive_nxt;
      bank_r     <= bank_nxt;
      bidx_r     <= bidx_nxt;
      blimit_r   <= blimit_nxt;
      low_r      <= low_nxt;
      status_r   <= status_nxt;
      xfer_r     <= xfer_nxt;
      res_rd_r   <= res_rd_nxt;
      res_dreq_r <= res_dreq_nxt;
      res_unit_r <= res_unit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_req_r  <= in_ch.req_type;
      item_port_r <= in_ch.port;
      item_data_r <= in_ch.data;
    end
  end

  // Configuration writes; indexes past the register list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= '0;
      wprot_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ATTACHED: attached_r <= cfg_ch.data;
        CFG_WPROT:    wprot_r    <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Output register. The offset is only meaningful with a request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rd_r   <= res_rd_r;
      out_dreq_r <= res_dreq_r;
      out_unit_r <= res_unit_r;
      out_offs_r <= (res_dreq_r != DREQ_NONE) ? offset : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rd_r;
  assign out_ch.disk_request = out_dreq_r;
  assign out_ch.disk_unit    = out_unit_r;
  assign out_ch.disk_offset  = out_offs_r;

  // --------------------------------------------------------------------------
  // Submodules.
  // --------------------------------------------------------------------------
  hdc_sector_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign geom.track  = track_r;
  assign geom.head0  = head_r[0];
  assign geom.sector = sector_r;

  hdc_offset_unit #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_offset (
    .clk    (clk),
    .geom   (geom),
    .offset (offset)
  );

endmodule

// ===== hdl/hdc_checker.sv =====
// ----------------------------------------------------------------------------
// hdc_checker: port-level checks for the disk controller port block
// Watches the channel handshakes and result fields over time.
// ----------------------------------------------------------------------------
module hdc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hdc_pkg::BYTE_W-1:0] out_read_data,
  input logic [hdc_pkg::DREQ_W-1:0] out_disk_request,
  input logic [hdc_pkg::UNIT_W-1:0] out_disk_unit,
  input logic [hdc_pkg::OFFS_W-1:0] out_disk_offset
);
  import hdc_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
    $stable(out_disk_request) && $stable(out_disk_unit) && $stable(out_disk_offset))
    else $error("result beat changed while stalled");

  // Without a disk request, unit and offset read as zero.
  a_no_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_disk_request == DREQ_NONE |->
    out_disk_unit == '0 && out_disk_offset == '0)
    else $error("unit or offset set without a disk request");

  // A disk request never comes with read data, and is a known code.
  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_disk_request != DREQ_NONE |->
    out_read_data == '0 &&
    (out_disk_request == DREQ_READ || out_disk_request == DREQ_WRITE))
    else $error("malformed disk request beat");

  // Items are handled one at a time: no input beat right after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hard_disk_controller_ports_core hdc_checker u_hdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_read_data    (out_ch.read_data),
  .out_disk_request (out_ch.disk_request),
  .out_disk_unit    (out_ch.disk_unit),
  .out_disk_offset  (out_ch.disk_offset)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the disk controller port block
// Drives host port accesses and disk transfer bytes into the controller,
// predicts result beats from a behavioral copy of the controller state
// and compares the beats field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import hdc_pkg::*;

  localparam int SECTOR_BYTES = 256;
  localparam int BUFFER_COUNT = 4;
  localparam int RANDOM_ITEMS = 800;
  // Mask settings change after this many further input beats.
  localparam int PHASE_ITEMS  = 160;
  // Cycles with no beat on any channel before the run is declared hung.
  localparam int BEAT_TIMEOUT = 1000;
  // Quiet cycles after the last result, to catch stray result beats.
  localparam int DRAIN_CYCLES = 10;

  // Codes the package does not name: any even port reads back ready, an
  // unused command nibble only clears status, an unused request type is a no-op.
  localparam logic [PORT_W-1:0] PORT_READY = 3'd0;
  localparam logic [3:0]        CMD_UNUSED = 4'hf;
  localparam logic [REQ_W-1:0]  RQ_UNUSED  = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] data;
  } hdc_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [DREQ_W-1:0] dreq;
    logic [UNIT_W-1:0] unit;
    logic [OFFS_W-1:0] offs;
  } hdc_result_t;

  // One row of the directed table: the beat and, where it is obvious,
  // the result typed in by hand.
  typedef struct packed {
    hdc_item_t   item;
    logic        typed;
    hdc_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdc_in_if  in_ch ();
  hdc_out_if out_ch ();
  hdc_cfg_if cfg_ch ();

  hard_disk_controller_ports_core #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .BUFFER_COUNT(BUFFER_COUNT)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Controller state as the bench believes it to be. It is advanced once per
  // accepted input beat, so at any point it reflects every beat sent so far.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]  sector_mem [0:BUFFER_COUNT*SECTOR_BYTES-1];
  bit                 mem_written [0:BUFFER_COUNT*SECTOR_BYTES-1];
  logic [BYTE_W-1:0]  att_mask = '0;
  logic [BYTE_W-1:0]  wp_mask  = '0;
  logic [TRACK_W-1:0] trk      = '0;
  logic [HEAD_W-1:0]  head     = '0;
  logic [SECT_W-1:0]  sect     = '0;
  logic [UNIT_W-1:0]  drive    = '0;
  logic [BANK_W-1:0]  bank     = '0;
  logic [BIDX_W-1:0]  bidx     = '0;
  logic [BIDX_W-1:0]  blimit   = 9'd256;
  logic [BYTE_W-1:0]  low_cmd  = '0;
  logic [BYTE_W-1:0]  status   = '0;
  logic [7:0]         xfer_idx = '0;

  hdc_result_t pending_results [$];
  stim_row_t   stim_rows [$];

  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int disk_requests = 0;
  int settings_used = 0;
  int in_quiet      = 0;
  int out_quiet     = 0;
  int cycles_since_beat = 0;

  function automatic int mem_addr(logic [8:0] idx);
    return (int'(bank) % BUFFER_COUNT) * SECTOR_BYTES + int'(idx) % SECTOR_BYTES;
  endfunction

  // The host may touch the buffer only below both the limit and the sector end.
  function automatic bit host_slot_open();
    return bidx < blimit && bidx < SECTOR_BYTES;
  endfunction

  function automatic logic [OFFS_W-1:0] sector_byte_offset();
    int unsigned lba;
    lba = (int'(trk) * 2 + int'(head[0])) * SECTORS_PER_TRACK + int'(sect);
    return OFFS_W'(lba * SECTOR_BYTES);
  endfunction

  // Applies one beat to the believed state and returns the result it causes.
  function automatic hdc_result_t controller_step(hdc_item_t it);
    hdc_result_t r;
    logic [3:0]  cmd;
    logic [8:0]  t;
    r = '0;
    cmd = it.data[7:4];
    case (it.req)
      RQ_HOST_RD: begin
        if (!it.port[0]) begin
          r.read_data = ST_READY;
        end else if (it.port == PORT_STATUS) begin
          r.read_data = status;
        end else if (it.port == PORT_DATA_RD && host_slot_open()) begin
          r.read_data = sector_mem[mem_addr(bidx)];
          bidx++;
        end
      end
      RQ_HOST_WR: begin
        if (it.port == PORT_DATA_WR) begin
          low_cmd = it.data;
          if (host_slot_open()) begin
            sector_mem[mem_addr(bidx)]  = it.data;
            mem_written[mem_addr(bidx)] = 1'b1;
            bidx++;
          end
        end else if (it.port == PORT_CMD) begin
          status = '0;
          case (cmd)
            CMD_TRACK_SEEK: begin
              t = {1'b0, low_cmd} + {it.data[0], 8'h00};
              trk = (t >= TRACK_COUNT) ? TRACK_W'(TRACK_COUNT - 1) : t;
            end
            CMD_WR_SEC, CMD_RD_SEC, CMD_RD_SEC_ALT: begin
              head  = low_cmd[6:5];
              drive = {it.data[3:2], head[1]};
              sect  = low_cmd[4:0];
              bank  = it.data[1:0];
              if (!att_mask[drive]) begin
                status = ST_NOT_READY;
              end else if (cmd == CMD_WR_SEC && wp_mask[drive]) begin
                status = ST_WRITE_LOCK;
              end else begin
                xfer_idx = '0;
                r.dreq = (cmd == CMD_WR_SEC) ? DREQ_WRITE : DREQ_READ;
                r.unit = drive;
                r.offs = sector_byte_offset();
              end
            end
            CMD_WR_BUF, CMD_RD_BUF: begin
              bank   = it.data[1:0];
              blimit = (low_cmd == 0) ? 9'd256 : {1'b0, low_cmd};
              bidx   = '0;
            end
            default: ;
          endcase
        end
      end
      RQ_DISK_IN: begin
        sector_mem[mem_addr(xfer_idx)]  = it.data;
        mem_written[mem_addr(xfer_idx)] = 1'b1;
        xfer_idx++;
      end
      RQ_DISK_PULL: begin
        r.read_data = sector_mem[mem_addr(xfer_idx)];
        xfer_idx++;
      end
      RQ_DISK_ERR: begin
        status   = ST_NOT_READY;
        xfer_idx = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Buffer bytes are undefined until written, so a read that would land on a
  // never-written byte is turned into the matching write instead.
  function automatic hdc_item_t avoid_unwritten_read(hdc_item_t it);
    if (it.req == RQ_HOST_RD && it.port == PORT_DATA_RD && host_slot_open() &&
        !mem_written[mem_addr(bidx)]) begin
      it.req  = RQ_HOST_WR;
      it.port = PORT_DATA_WR;
    end
    if (it.req == RQ_DISK_PULL && !mem_written[mem_addr(xfer_idx)])
      it.req = RQ_DISK_IN;
    return it;
  endfunction

  // Idle gap before the next beat, drawn at random, with occasional streaks of
  // back-to-back beats so that both sparse and dense traffic are seen.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_row(logic [REQ_W-1:0] req, logic [PORT_W-1:0] port,
                                  logic [BYTE_W-1:0] data, logic typed,
                                  logic [BYTE_W-1:0] rd, logic [DREQ_W-1:0] dreq,
                                  logic [UNIT_W-1:0] unit, logic [OFFS_W-1:0] offs);
    stim_rows.push_back({req, port, data, typed, rd, dreq, unit, offs});
  endfunction

  // --------------------------------------------------------------------------
  // Input side. A beat is driven at a falling edge and held until a rising
  // edge sees ready. valid stays high into the next beat when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_item(hdc_item_t it, logic typed, hdc_result_t typed_res);
    int          gap;
    hdc_result_t predicted;
    gap = draw_gap(in_quiet);
    it = avoid_unwritten_read(it);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= it.req;
    in_ch.port     <= it.port;
    in_ch.data     <= it.data;
    do @(posedge clk); while (!in_ch.ready);
    // Accepted: the hand-typed result, where there is one, must agree with
    // the hardware, but the believed state always advances.
    predicted = controller_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (predicted.dreq != DREQ_NONE)
      disk_requests++;
  endtask

  task automatic send_rand(logic [REQ_W-1:0] req, logic [PORT_W-1:0] port,
                           logic [BYTE_W-1:0] data);
    send_item({req, port, data}, 1'b0, '0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_ATTACHED)
      att_mask = value;
    else
      wp_mask = value;
  endtask

  // Masks change only with the controller idle: stop sending, let every
  // outstanding result come back, then write both registers.
  task automatic program_masks(logic [BYTE_W-1:0] att, logic [BYTE_W-1:0] wp);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(CFG_ATTACHED, att);
    write_reg(CFG_WPROT, wp);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // One well-formed host or disk exchange with random content, or a burst
  // of fully random beats.
  task automatic random_sequence();
    int         kind;
    int         n;
    logic [7:0] lim;
    logic [3:0] cmd;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        // Buffer fill (port 7) or drain (port 5), running a little past the
        // limit so the exhausted-buffer path is hit as well.
        lim = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
        if (lim == 0)
          n = ($urandom_range(0, 5) == 0) ? 258 : $urandom_range(1, 30);
        else
          n = lim + $urandom_range(0, 3);
        cmd = (kind < 2) ? CMD_WR_BUF : CMD_RD_BUF;
        send_rand(RQ_HOST_WR, PORT_DATA_WR, lim);
        send_rand(RQ_HOST_WR, PORT_CMD, {cmd, 4'($urandom_range(0, 15))});
        repeat (n) begin
          if (kind < 2)
            send_rand(RQ_HOST_WR, PORT_DATA_WR, 8'($urandom));
          else
            send_rand(RQ_HOST_RD, PORT_DATA_RD, 8'($urandom));
        end
        send_rand(RQ_HOST_RD, PORT_STATUS, 8'($urandom));
      end
      4, 5, 6: begin
        // Sector command, status poll, then the disk moving bytes, with a
        // rare disk error in the middle of the transfer.
        case ($urandom_range(0, 2))
          0:       cmd = CMD_WR_SEC;
          1:       cmd = CMD_RD_SEC;
          default: cmd = CMD_RD_SEC_ALT;
        endcase
        send_rand(RQ_HOST_WR, PORT_DATA_WR, 8'($urandom));
        send_rand(RQ_HOST_WR, PORT_CMD, {cmd, 4'($urandom_range(0, 15))});
        send_rand(RQ_HOST_RD, PORT_STATUS, 8'($urandom));
        n = $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 39) == 0)
            send_rand(RQ_DISK_ERR, 3'($urandom), 8'($urandom));
          else if (cmd == CMD_WR_SEC)
            send_rand(RQ_DISK_PULL, 3'($urandom), 8'($urandom));
          else
            send_rand(RQ_DISK_IN, 3'($urandom), 8'($urandom));
        end
      end
      7: begin
        send_rand(RQ_HOST_WR, PORT_DATA_WR, 8'($urandom));
        send_rand(RQ_HOST_WR, PORT_CMD, {CMD_TRACK_SEEK, 4'($urandom_range(0, 15))});
      end
      default: begin
        repeat ($urandom_range(1, 6))
          send_rand(3'($urandom), 3'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // Mask settings per random phase: three extremes, then two random, repeating.
  function automatic logic [15:0] mask_setting(int phase);
    case (phase % 5)
      0:       return {8'hff, 8'h00};
      1:       return {8'h00, 8'hff};
      2:       return {8'hff, 8'hff};
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main stimulus: reset, directed table, then random phases.
  // --------------------------------------------------------------------------
  initial begin
    int          phase;
    int          next_switch;
    logic [15:0] masks;
    in_ch.valid    = 1'b0;
    in_ch.req_type = '0;
    in_ch.port     = '0;
    in_ch.data     = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;

    // Directed table. The running comments track the controller state that
    // the hand-typed results rely on; drive 7 is detached and drive 0 locked.
    add_row(RQ_HOST_RD, PORT_READY,   8'h00, 1'b1, ST_READY, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_STATUS,  8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    // Reads of the command and data-out ports return zero.
    add_row(RQ_HOST_RD, PORT_CMD,     8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_DATA_WR, 8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    // Low byte 0xff, then a seek with bit 8 set: track 511 clamps to 405.
    add_row(RQ_HOST_WR, PORT_DATA_WR, 8'hff, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_TRACK_SEEK, 4'h1}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    // Head 3, sector 31. Unit 3 with head bit 1 addresses detached drive 7.
    add_row(RQ_HOST_WR, PORT_DATA_WR, 8'h7f, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_RD_SEC, 2'd3, 2'd0}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_STATUS,  8'h00, 1'b1, ST_NOT_READY, DREQ_NONE, 0, 0);
    // Alternate read code to drive 3 at the far end of the disk: largest offset.
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_RD_SEC_ALT, 2'd1, 2'd1}, 1'b1,
            8'h00, DREQ_READ, 3'd3, 23'd4990720);
    // Disk byte into buffer 1, a disk error rewinds the transfer, pull it back.
    add_row(RQ_DISK_IN,   PORT_READY, 8'hff, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_DISK_ERR,  PORT_READY, 8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_DISK_PULL, PORT_READY, 8'h00, 1'b1, 8'hff, DREQ_NONE, 0, 0);
    // Sector write to the locked drive 0.
    add_row(RQ_HOST_WR, PORT_DATA_WR, 8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_WR_SEC, 2'd0, 2'd0}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_STATUS,  8'h00, 1'b1, ST_WRITE_LOCK, DREQ_NONE, 0, 0);
    // Read buffer 1 with a zero limit byte, meaning a whole sector.
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_RD_BUF, 2'd0, 2'd1}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_DATA_RD, 8'h00, 1'b0, 8'h00, DREQ_NONE, 0, 0);
    // Write buffer 2 with a limit of one byte, fill it, then overrun it with a read.
    add_row(RQ_HOST_WR, PORT_DATA_WR, 8'h01, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_WR_BUF, 2'd0, 2'd2}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_DATA_WR, 8'haa, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_RD, PORT_DATA_RD, 8'h00, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    // Ignored port write, an unused command code and an unused request type.
    add_row(RQ_HOST_WR, PORT_STATUS,  8'h55, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_UNUSED, 4'h3}, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    add_row(RQ_UNUSED,  PORT_DATA_WR, 8'hff, 1'b1, 8'h00, DREQ_NONE, 0, 0);
    // Successful sector write request, offset left to the predictor.
    add_row(RQ_HOST_WR, PORT_CMD, {CMD_WR_SEC, 2'd1, 2'd0}, 1'b0, 8'h00, DREQ_NONE, 0, 0);

    // Synchronous reset, released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    program_masks(8'h7f, 8'h01);
    foreach (stim_rows[i])
      send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);

    phase = 0;
    next_switch = items_sent;
    while (items_sent < stim_rows.size() + RANDOM_ITEMS) begin
      if (items_sent >= next_switch) begin
        masks = mask_setting(phase);
        program_masks(masks[15:8], masks[7:0]);
        phase++;
        next_switch = items_sent + PHASE_ITEMS;
      end
      random_sequence();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats and %0d result beats, %0d of them disk requests,",
             items_sent, results_seen, disk_requests);
    $display("under %0d attached/write-protect mask settings.", settings_used);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and every accepted beat is compared
  // with the oldest outstanding prediction.
  // --------------------------------------------------------------------------
  initial begin
    int          gap;
    hdc_result_t want;
    hdc_result_t got;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = draw_gap(out_quiet);
      @(negedge clk);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.read_data, out_ch.disk_request, out_ch.disk_unit, out_ch.disk_offset};
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, expected none, got 0x%0h",
                 $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data",    want.read_data, got.read_data);
        check_field("disk_request", want.dreq,      got.dreq);
        check_field("disk_unit",    want.unit,      got.unit);
        check_field("disk_offset",  want.offs,      got.offs);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any beat on any channel resets the count of idle cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      cycles_since_beat <= 0;
    end else begin
      cycles_since_beat <= cycles_since_beat + 1;
    end
  end

  initial begin
    wait (cycles_since_beat >= BEAT_TIMEOUT);
    $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
             $time, BEAT_TIMEOUT, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
